FILE: rtl/sks_pkg.sv
// Shared types and constants for the scalar Kalman smoother.
// Payload structs, controller/datapath command and status, register map codes.
// No dependencies.
`default_nettype none
package sks_pkg;

  typedef struct packed {
    logic signed [31:0] measured_sample;
    logic        [31:0] elapsed_time;
  } sks_in_t;

  typedef struct packed {
    logic signed [31:0] filtered_value;
    logic signed [31:0] prior_estimate;
    logic        [16:0] gain_out;
    logic        [31:0] variance_out;
  } sks_out_t;

  // Q16.16 / Q1.16 constants
  localparam logic [16:0] ONE_Q16     = 17'h1_0000;
  localparam logic [31:0] VAR_MAX     = 32'hFFFF_FFFF;
  localparam logic [31:0] SNV_RESET   = 32'h0001_0000;
  localparam logic [31:0] IEV_RESET   = 32'h0001_0000;
  localparam logic [4:0]  DIV_STEPS_M1 = 5'd16;

  typedef enum logic [1:0] {
    REG_SNV = 2'd0,
    REG_IEV = 2'd1,
    REG_RNV = 2'd2,
    REG_PNC = 2'd3
  } sks_reg_t;

  // operand pairs for the shared multiplier
  typedef enum logic [1:0] {
    MUL_RATE = 2'd0,
    MUL_VAR  = 2'd1,
    MUL_MEAS = 2'd2,
    MUL_OLD  = 2'd3
  } sks_mul_sel_t;

  typedef struct packed {
    logic         sample_load;
    logic         mul_en;
    sks_mul_sel_t mul_sel;
    logic         sum_load;
    logic         div_init;
    logic         div_step;
    logic         gain_load;
    logic         var_load;
    logic         acc_load;
    logic         commit;
    logic         result_load;
  } sks_cmd_t;

  typedef struct packed {
    logic hold;
    logic div_last;
  } sks_status_t;

endpackage
`default_nettype wire

FILE: rtl/sks_datapath.sv
// Datapath of the scalar Kalman smoother: shared multiplier, serial divider,
// filter state and the result register. Driven by sks_ctrl; uses sks_pkg.
`default_nettype none
module sks_datapath (
  input  logic                clk,
  input  logic                rst,
  input  sks_pkg::sks_cmd_t    cmd,
  output sks_pkg::sks_status_t status,
  input  sks_pkg::sks_in_t     sample,
  input  logic [31:0]         snv,
  input  logic [31:0]         rnv,
  input  logic [31:0]         pnc,
  input  logic                var_wr,
  input  logic [31:0]         var_wdata,
  output sks_pkg::sks_out_t    result
);
  import sks_pkg::*;

  // item registers
  logic signed [31:0] meas;
  logic        [31:0] dt;
  logic        [63:0] prod;
  logic        [31:0] p;
  logic        [32:0] denom;
  logic        [33:0] rem;
  logic        [16:0] quo;
  logic        [4:0]  div_cnt;
  logic        [16:0] gain;
  logic        [31:0] var_new;
  logic signed [48:0] acc;

  // filter state
  logic        [31:0] est_var;
  logic signed [31:0] cur_est;
  logic signed [31:0] prev_est;
  logic        [16:0] cur_gain;

  logic signed [32:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [65:0] mul_full;
  logic        [16:0] omk;
  logic        [48:0] psum;
  logic               rem_ge;
  logic        [33:0] rem_sub;
  logic signed [48:0] blend_sum;

  assign omk = ONE_Q16 - gain;

  always_comb begin
    case (cmd.mul_sel)
      MUL_RATE: begin
        mul_a = {1'b0, rnv};
        mul_b = {1'b0, dt};
      end
      MUL_VAR: begin
        mul_a = {1'b0, p};
        mul_b = {16'b0, omk};
      end
      MUL_MEAS: begin
        mul_a = {meas[31], meas};
        mul_b = {16'b0, gain};
      end
      default: begin
        mul_a = {cur_est[31], cur_est};
        mul_b = {16'b0, omk};
      end
    endcase
  end

  assign mul_full = mul_a * mul_b;

  // grown variance: P + Q + (rate * dt >> 16), saturated to 32 bits
  assign psum = {17'b0, est_var} + {17'b0, pnc} + {1'b0, prod[63:16]};

  // restoring divider step; remainder stays below twice the divisor
  assign rem_ge  = (rem >= {1'b0, denom});
  assign rem_sub = rem_ge ? (rem - {1'b0, denom}) : rem;

  // rounded half up, arithmetic shift by 16
  assign blend_sum = acc + $signed(prod[48:0]) + 49'sd32768;

  always_ff @(posedge clk) begin
    if (cmd.sample_load) begin
      meas <= sample.measured_sample;
      dt   <= sample.elapsed_time;
    end
    if (cmd.mul_en) begin
      prod <= mul_full[63:0];
    end
    if (cmd.sum_load) begin
      p <= (|psum[48:32]) ? VAR_MAX : psum[31:0];
    end
    if (cmd.div_init) begin
      denom <= {1'b0, p} + {1'b0, snv};
      rem   <= {2'b0, p};
      quo   <= '0;
    end else if (cmd.div_step) begin
      rem <= {rem_sub[32:0], 1'b0};
      quo <= {quo[15:0], rem_ge};
    end
    if (cmd.gain_load) begin
      if (denom == '0) begin
        gain <= '0;
      end else if (quo > ONE_Q16) begin
        gain <= ONE_Q16;
      end else begin
        gain <= quo;
      end
    end
    if (cmd.var_load) begin
      var_new <= prod[47:16];
    end
    if (cmd.acc_load) begin
      acc <= $signed(prod[48:0]);
    end
    if (cmd.result_load) begin
      result.filtered_value <= cur_est;
      result.prior_estimate <= prev_est;
      result.gain_out       <= cur_gain;
      result.variance_out   <= est_var;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      div_cnt <= '0;
    end else if (cmd.div_init) begin
      div_cnt <= DIV_STEPS_M1;
    end else if (cmd.div_step && div_cnt != '0) begin
      div_cnt <= div_cnt - 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      est_var  <= IEV_RESET;
      cur_est  <= '0;
      prev_est <= '0;
      cur_gain <= '0;
    end else if (var_wr) begin
      est_var <= var_wdata;
    end else if (cmd.commit) begin
      est_var  <= var_new;
      prev_est <= cur_est;
      cur_est  <= blend_sum[47:16];
      cur_gain <= gain;
    end
  end

  assign status.hold     = (dt == '0);
  assign status.div_last = (div_cnt == '0);

endmodule
`default_nettype wire

FILE: rtl/sks_ctrl.sv
// Sequencer for the scalar Kalman smoother: handshakes and datapath commands.
// Uses sks_pkg; pairs with sks_datapath.
`default_nettype none
module sks_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                sample_valid,
  output logic                sample_ready,
  output logic                result_valid,
  input  logic                result_ready,
  output sks_pkg::sks_cmd_t    cmd,
  input  sks_pkg::sks_status_t status
);
  import sks_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE  = 11'b000_0000_0001,
    S_RATE  = 11'b000_0000_0010,
    S_SUM   = 11'b000_0000_0100,
    S_DINIT = 11'b000_0000_1000,
    S_DIV   = 11'b000_0001_0000,
    S_GAIN  = 11'b000_0010_0000,
    S_MVAR  = 11'b000_0100_0000,
    S_MMEAS = 11'b000_1000_0000,
    S_MOLD  = 11'b001_0000_0000,
    S_BLEND = 11'b010_0000_0000,
    S_OUT   = 11'b100_0000_0000
  } state_t;

  state_t state;
  state_t state_next;
  logic   result_valid_next;
  logic   slot_free;

  assign sample_ready = (state == S_IDLE);
  assign slot_free    = !result_valid || result_ready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.mul_sel = MUL_RATE;
    unique case (state)
      S_IDLE: begin
        if (sample_valid) begin
          cmd.sample_load = 1'b1;
          state_next      = S_RATE;
        end
      end
      S_RATE: begin
        // zero elapsed time: report the stored state unchanged
        if (status.hold) begin
          state_next = S_OUT;
        end else begin
          cmd.mul_en = 1'b1;
          state_next = S_SUM;
        end
      end
      S_SUM: begin
        cmd.sum_load = 1'b1;
        state_next   = S_DINIT;
      end
      S_DINIT: begin
        cmd.div_init = 1'b1;
        state_next   = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = S_GAIN;
        end
      end
      S_GAIN: begin
        cmd.gain_load = 1'b1;
        state_next    = S_MVAR;
      end
      S_MVAR: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_VAR;
        state_next  = S_MMEAS;
      end
      S_MMEAS: begin
        cmd.var_load = 1'b1;
        cmd.mul_en   = 1'b1;
        cmd.mul_sel  = MUL_MEAS;
        state_next   = S_MOLD;
      end
      S_MOLD: begin
        cmd.acc_load = 1'b1;
        cmd.mul_en   = 1'b1;
        cmd.mul_sel  = MUL_OLD;
        state_next   = S_BLEND;
      end
      S_BLEND: begin
        cmd.commit = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (slot_free) begin
          cmd.result_load = 1'b1;
          state_next      = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.result_load) begin
      result_valid_next = 1'b1;
    end else if (result_ready) begin
      result_valid_next = 1'b0;
    end else begin
      result_valid_next = result_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= result_valid_next;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/scalar_kalman_smoother.sv
// Scalar Kalman smoother, Q16.16. A sample with zero elapsed time is a hold:
// the stored state is reported unchanged. An update runs the 17-step serial
// gain divider and four passes through the shared 33x33 multiplier. One sample
// is worked on at a time; the next is taken once the last result is loaded.
// A result waits in an output register while the next sample is taken.
// Reset (rst, synchronous): registers to defaults, variance to 1.0, state zero.
`default_nettype none
module scalar_kalman_smoother (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  logic              sample_valid,
  output logic              sample_ready,
  input  sks_pkg::sks_in_t  sample,
  output logic              result_valid,
  input  logic              result_ready,
  output sks_pkg::sks_out_t result
);
  import sks_pkg::*;

  logic [31:0] snv;
  logic [31:0] iev;
  logic [31:0] rnv;
  logic [31:0] pnc;
  logic        wr_en;
  sks_reg_t    reg_sel;
  logic        var_wr;
  sks_cmd_t    cmd;
  sks_status_t status;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = sks_reg_t'(paddr[3:2]);
  assign var_wr  = wr_en && (reg_sel == REG_IEV);

  always_ff @(posedge clk) begin
    if (rst) begin
      snv <= SNV_RESET;
      iev <= IEV_RESET;
      rnv <= '0;
      pnc <= '0;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_SNV: snv <= pwdata;
        REG_IEV: iev <= pwdata;
        REG_RNV: rnv <= pwdata;
        REG_PNC: pnc <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_SNV: prdata = snv;
      REG_IEV: prdata = iev;
      REG_RNV: prdata = rnv;
      REG_PNC: prdata = pnc;
      default: prdata = '0;
    endcase
  end

  sks_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .cmd          (cmd),
    .status       (status)
  );

  sks_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .sample    (sample),
    .snv       (snv),
    .rnv       (rnv),
    .pnc       (pnc),
    .var_wr    (var_wr),
    .var_wdata (pwdata),
    .result    (result)
  );

endmodule
`default_nettype wire

FILE: rtl/sks_checker.sv
// Port-level checks for scalar_kalman_smoother, attached with bind.
// Uses sks_pkg for the payload types.
`default_nettype none
module sks_checker (
  input logic              clk,
  input logic              rst,
  input logic              pready,
  input logic              sample_valid,
  input logic              sample_ready,
  input logic              result_valid,
  input logic              result_ready,
  input sks_pkg::sks_out_t result
);
  import sks_pkg::*;

  // one sample in flight: no new transfer right after one is taken
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    sample_valid && sample_ready |=> !sample_ready)
    else $error("sample taken while previous one in progress");

  // a pending result holds until its transfer
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("pending result dropped or changed");

  // gain never exceeds one
  a_gain_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.gain_out <= ONE_Q16)
    else $error("gain above one");

  // a result never appears while the block is ready for a sample
  // unless it was already pending
  a_result_after_work: assert property (@(posedge clk) disable iff (rst)
    !result_valid && sample_ready |=> !result_valid)
    else $error("result without a sample");

  a_pready: assert property (@(posedge clk) disable iff (rst) pready)
    else $error("pready low");

endmodule

bind scalar_kalman_smoother sks_checker u_sks_checker (
  .clk          (clk),
  .rst          (rst),
  .pready       (pready),
  .sample_valid (sample_valid),
  .sample_ready (sample_ready),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result       (result)
);
`default_nettype wire

FILE: verif/tb_scalar_kalman_smoother.sv
// Self-checking testbench for scalar_kalman_smoother: random Q16.16 samples, APB register
// phases, in-bench prediction of every result, random stalls on both streams.
// Depends on rtl/sks_pkg.sv and rtl/scalar_kalman_smoother.sv.
module tb_scalar_kalman_smoother;
  timeunit 1ns;
  timeprecision 1ps;
  import sks_pkg::*;

  localparam int CYCLE_LIMIT  = 600_000;
  localparam int ITEMS_PER_PH = 156;
  localparam int RAND_PHASES  = 8;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        sample_valid = 1'b0;
  logic        sample_ready;
  sks_in_t     sample = '0;
  logic        result_valid;
  logic        result_ready = 1'b0;
  sks_out_t    result;

  scalar_kalman_smoother dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .sample_valid(sample_valid), .sample_ready(sample_ready), .sample(sample),
    .result_valid(result_valid), .result_ready(result_ready), .result(result)
  );

  always #2 clk = ~clk;

  // filter state and register shadow
  logic [31:0] meas_noise  = SNV_RESET;
  logic [31:0] start_var   = IEV_RESET;
  logic [31:0] rate_noise  = '0;
  logic [31:0] const_noise = '0;
  logic [31:0] est_var     = IEV_RESET;
  logic [31:0] cur_est     = '0;
  logic [31:0] prev_est    = '0;
  logic [16:0] cur_gain    = '0;

  sks_in_t  pending_samples[$];
  sks_out_t expected_estimates[$];
  sks_out_t want;
  int       errors = 0;
  int       results_seen = 0;
  int       cycle_count = 0;

  logic in_xfer = 1'b0, out_xfer = 1'b0;
  logic tx_fast = 1'b0, rx_fast = 1'b0;
  int unsigned tx_gap = 0, rx_gap = 0, rx_draw;
  int unsigned stall_left = 0;
  logic long_stall_done = 1'b0;

  // One filter step; updates the predicted state.
  function automatic sks_out_t kalman_update(input sks_in_t s);
    logic [63:0] rate_term, grown, denom, quot, one_minus;
    logic [16:0] k;
    longint      m, old, kk, acc;
    sks_out_t    r;
    if (s.elapsed_time != '0) begin
      rate_term = ({32'd0, rate_noise} * {32'd0, s.elapsed_time}) >> 16;
      grown = {32'd0, est_var} + {32'd0, const_noise} + rate_term;
      if (grown > {32'd0, VAR_MAX}) grown = {32'd0, VAR_MAX};
      denom = grown + {32'd0, meas_noise};
      quot = (denom == 64'd0) ? 64'd0 : (grown << 16) / denom;
      k = (quot > {47'd0, ONE_Q16}) ? ONE_Q16 : quot[16:0];
      one_minus = {47'd0, ONE_Q16} - {47'd0, k};
      est_var = 32'((grown * one_minus) >> 16);
      m = $signed(s.measured_sample);
      old = $signed(cur_est);
      kk = k;
      // convex blend, rounded half up
      acc = m * kk + old * (longint'(ONE_Q16) - kk) + 32768;
      prev_est = cur_est;
      cur_est = 32'(acc >>> 16);
      cur_gain = k;
    end
    r.filtered_value = cur_est;
    r.prior_estimate = prev_est;
    r.gain_out = cur_gain;
    r.variance_out = est_var;
    return r;
  endfunction

  function automatic logic [31:0] reg_shadow(input sks_reg_t idx);
    case (idx)
      REG_SNV: return meas_noise;
      REG_IEV: return start_var;
      REG_RNV: return rate_noise;
      default: return const_noise;
    endcase
  endfunction

  function automatic logic [31:0] pick_variance(input bit wide);
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return VAR_MAX;
      2: return 32'h0001_0000;
      3: return $urandom_range(0, 32'h0004_0000);
      4: return wide ? $urandom : $urandom_range(0, 32'h0000_4000);
      default: return $urandom_range(1, 32'h0010_0000);
    endcase
  endfunction

  task automatic check_field(input string label, input logic [31:0] exp_v, got_v);
    if (got_v !== exp_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, got %h", $time, label, exp_v, got_v);
    end
  endtask

  task automatic reg_write(input sks_reg_t idx, input logic [31:0] val);
    @(negedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= {idx, 2'b00}; pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_SNV: meas_noise = val;
      REG_IEV: begin
        start_var = val;
        est_var = val;
      end
      REG_RNV: rate_noise = val;
      REG_PNC: const_noise = val;
    endcase
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  task automatic reg_read_check(input sks_reg_t idx);
    @(negedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b0; paddr <= {idx, 2'b00};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    check_field(idx.name(), reg_shadow(idx), prdata);
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0;
  endtask

  task automatic set_config(input logic [31:0] r, p0, rate, pc);
    reg_write(REG_SNV, r);
    reg_write(REG_IEV, p0);
    reg_write(REG_RNV, rate);
    reg_write(REG_PNC, pc);
    reg_read_check(REG_SNV);
    reg_read_check(REG_IEV);
    reg_read_check(REG_RNV);
    reg_read_check(REG_PNC);
  endtask

  task automatic offer(input logic [31:0] m, dt);
    sks_in_t s;
    s.measured_sample = m;
    s.elapsed_time = dt;
    pending_samples.push_back(s);
  endtask

  // sender holds off until the block has drained
  task automatic wait_drained(input int settle);
    while (pending_samples.size() != 0 || sample_valid || expected_estimates.size() != 0)
      @(negedge clk);
    repeat (settle) @(negedge clk);
  endtask

  // sample driver
  always @(negedge clk) begin
    if (rst) begin
      sample_valid <= 1'b0;
      tx_gap <= 0;
    end else if (sample_valid && !in_xfer) begin
      // hold the offered transfer
    end else if (tx_gap != 0) begin
      sample_valid <= 1'b0;
      tx_gap <= tx_gap - 1;
    end else if (pending_samples.size() != 0) begin
      sample <= pending_samples.pop_front();
      sample_valid <= 1'b1;
      tx_gap <= tx_fast ? 0 : $urandom_range(0, 15);
      if ($urandom_range(0, 31) == 0) tx_fast <= ~tx_fast;
    end else begin
      sample_valid <= 1'b0;
    end
  end

  // sample monitor: predict on every accepted transfer
  always @(posedge clk) begin
    in_xfer <= !rst && sample_valid && sample_ready;
    if (!rst && sample_valid && sample_ready)
      expected_estimates.push_back(kalman_update(sample));
  end

  // result ready driver, with one long back-pressure stretch
  always @(negedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
      rx_gap <= 0;
    end else if (!long_stall_done && results_seen >= 200) begin
      result_ready <= 1'b0;
      stall_left <= 500;
      long_stall_done <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      result_ready <= (stall_left == 1);
    end else if (out_xfer) begin
      rx_draw = rx_fast ? 0 : $urandom_range(0, 15);
      if ($urandom_range(0, 31) == 0) rx_fast <= ~rx_fast;
      if (rx_draw == 0) begin
        result_ready <= 1'b1;
      end else begin
        result_ready <= 1'b0;
        rx_gap <= rx_draw - 1;
      end
    end else if (!result_ready) begin
      if (rx_gap == 0) result_ready <= 1'b1;
      else rx_gap <= rx_gap - 1;
    end
  end

  // result monitor
  always @(posedge clk) begin
    out_xfer <= !rst && result_valid && result_ready;
    if (!rst && result_valid && result_ready) begin
      results_seen++;
      if (expected_estimates.size() == 0) begin
        errors++;
        $display("%0t: unexpected result transfer, expected none, got %h", $time, result);
      end else begin
        want = expected_estimates.pop_front();
        check_field("filtered_value", want.filtered_value, result.filtered_value);
        check_field("prior_estimate", want.prior_estimate, result.prior_estimate);
        check_field("gain_out", {15'd0, want.gain_out}, {15'd0, result.gain_out});
        check_field("variance_out", want.variance_out, result.variance_out);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("scalar_kalman_smoother test failed");
      $finish;
    end
  end

  initial begin
    logic [31:0] dt, m;
    int unsigned sel;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset values, holds before and between updates, field extremes
    offer(32'h7FFF_FFFF, 32'd0);
    offer(32'h7FFF_FFFF, 32'd1);
    offer(32'h8000_0000, 32'hFFFF_FFFF);
    offer(32'hFFFF_FFFF, 32'h0001_0000);
    offer(32'h0000_0000, 32'd0);
    offer(32'h8000_0000, 32'h8000_0000);
    offer(32'h7FFF_FFFF, 32'h0000_8000);
    wait_drained(30);

    // zero variance and zero noise: P + R is zero, gain stays zero
    set_config(32'd0, 32'd0, 32'd0, 32'd0);
    offer(32'h1234_5678, 32'h0001_0000);
    offer(32'h8000_0000, 32'hFFFF_FFFF);
    offer(32'h7FFF_FFFF, 32'd0);
    wait_drained(30);

    // zero R with growing P: gain reaches one
    set_config(32'd0, 32'd0, 32'h0001_0000, 32'd1);
    offer(32'h7FFF_FFFF, 32'h0001_0000);
    offer(32'h8000_0000, 32'd1);
    wait_drained(30);

    // everything at full scale: variance saturates
    set_config(VAR_MAX, VAR_MAX, VAR_MAX, VAR_MAX);
    offer(32'h7FFF_FFFF, 32'hFFFF_FFFF);
    offer(32'h8000_0000, 32'h0000_0001);
    offer(32'h0000_0000, 32'd0);
    offer(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    wait_drained(30);

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      set_config(pick_variance(1'b1), pick_variance(1'b1),
                 pick_variance(1'b0), pick_variance(1'b0));
      for (int i = 0; i < ITEMS_PER_PH; i++) begin
        sel = $urandom_range(0, 9);
        if (sel == 0) dt = 32'd0;
        else if (sel <= 5) dt = $urandom_range(1, 32'h0003_0000);
        else if (sel <= 8) dt = $urandom;
        else dt = 32'hFFFF_FFFF;
        sel = $urandom_range(0, 15);
        if (sel == 0) m = 32'h7FFF_FFFF;
        else if (sel == 1) m = 32'h8000_0000;
        else m = $urandom;
        offer(m, dt);
      end
      wait_drained(30);
    end

    repeat (40) @(negedge clk);
    if (errors == 0) begin
      $display("scalar_kalman_smoother test passed");
    end else begin
      $display("scalar_kalman_smoother test failed");
    end
    $finish;
  end

endmodule

FILE: scalar_kalman_smoother.f
rtl/sks_pkg.sv
rtl/sks_datapath.sv
rtl/sks_ctrl.sv
rtl/scalar_kalman_smoother.sv
rtl/sks_checker.sv
verif/tb_scalar_kalman_smoother.sv
